FILE: design/hup_pkg.sv
// shared types and character constants for the http url host/port parser
// no dependencies; imported by http_url_host_port_parser_top
package hup_pkg;

	// result item kinds
	localparam logic [1:0] KIND_HOST  = 2'd0;
	localparam logic [1:0] KIND_PATH  = 2'd1;
	localparam logic [1:0] KIND_FINAL = 2'd2;

	// summary status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_SCHEME = 2'd1;
	localparam logic [1:0] ST_BAD_HOST   = 2'd2;
	localparam logic [1:0] ST_BAD_PORT   = 2'd3;

	// characters
	localparam logic [7:0] CH_H      = "h";
	localparam logic [7:0] CH_T      = "t";
	localparam logic [7:0] CH_P      = "p";
	localparam logic [7:0] CH_S      = "s";
	localparam logic [7:0] CH_COLON  = ":";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_DOT    = ".";
	localparam logic [7:0] CH_DASH   = "-";
	localparam logic [7:0] CH_0      = "0";
	localparam logic [7:0] CH_9      = "9";
	localparam logic [7:0] CH_LA     = "a";
	localparam logic [7:0] CH_LZ     = "z";
	localparam logic [7:0] CH_UA     = "A";
	localparam logic [7:0] CH_UZ     = "Z";
	localparam logic [7:0] CASE_STEP = 8'd32;

	localparam logic [15:0] PORT_HTTP  = 16'd80;
	localparam logic [15:0] PORT_HTTPS = 16'd443;
	localparam logic [2:0]  HOST_MIN   = 3'd4;

	// one result item as held in the output buffer
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  text;
		logic [1:0]  status;
		logic        secure;
		logic        port_given;
		logic [15:0] port_num;
		logic        path_given;
		logic        run_end;
	} res_t;

endpackage

FILE: design/http_url_host_port_parser_top.sv
// http/https url parser: streams host and path bytes, then a summary item
// depends on hup_pkg
//
// usage: url bytes enter on the in channel (url_byte, final_byte) under in_valid/in_ready,
// final_byte marking the last byte of a url. results leave on the out channel under
// out_valid/out_ready: host bytes (lower case), path bytes, and one summary item per url
// carrying status, scheme, port and path flags; run_end marks the last result of a byte.
// an accepted byte is held in the input register, parsed there, and its results
// (none to three) load a three-slot output buffer; the first result is visible the
// cycle after the load. throughput is one byte per cycle while each byte yields at most
// one result and out_ready stays high; a byte with results waits in the input register
// until the buffer is empty or its last item is leaving, the single output port draining
// it one item per cycle while out_ready is high. bytes with no result never wait on it.
// when the receiver stalls the buffer fills and in_ready falls; nothing is dropped.
// after the final byte the parser returns to its reset state for the next url.
// reset (arst_n low) empties both registers and puts the parser in scheme matching.
module http_url_host_port_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  url_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  item_kind,
	output logic [7:0]  text_byte,
	output logic [1:0]  status,
	output logic        secure_scheme,
	output logic        port_given,
	output logic [15:0] port_number,
	output logic        path_given,
	output logic        run_end
);
	import hup_pkg::*;

	typedef enum logic [2:0] {
		PH_SCHEME,
		PH_HOST,
		PH_PORT,
		PH_PATH,
		PH_IGNORE
	} phase_t;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// parser state
	phase_t      phase_q, n_phase;
	logic [2:0]  spos_q, n_spos;
	logic        secure_q, n_secure;
	logic        dot_ok_q, n_dot_ok;
	logic        seen_dot_q, n_seen_dot;
	logic [2:0]  hcount_q, n_hcount;
	logic [15:0] port_q, n_port;
	logic        pdigit_q, n_pdigit;
	logic        povf_q, n_povf;
	logic        slash_q, n_slash;
	logic        path_q, n_path;
	logic [1:0]  err_q, n_err;

	// output buffer, slot 0 is presented
	res_t       slot_q [3];
	logic [1:0] cnt_q;

	res_t       res [3];
	logic [1:0] nres;
	logic [7:0] lc;
	logic       is_alnum;
	logic       is_digit;
	logic [19:0] pv;
	logic       host_bad;
	logic       port_bad;
	logic       given;
	logic       ok;

	logic out_acc, in_acc, room, take, load;

	always_comb begin
		n_phase    = phase_q;
		n_spos     = spos_q;
		n_secure   = secure_q;
		n_dot_ok   = dot_ok_q;
		n_seen_dot = seen_dot_q;
		n_hcount   = hcount_q;
		n_port     = port_q;
		n_pdigit   = pdigit_q;
		n_povf     = povf_q;
		n_slash    = slash_q;
		n_path     = path_q;
		n_err      = err_q;
		res        = '{default: '0};
		nres       = 2'd0;
		ok         = 1'b0;
		host_bad   = 1'b0;
		port_bad   = 1'b0;
		given      = 1'b0;

		lc = (byte_s1 >= CH_UA && byte_s1 <= CH_UZ) ? byte_s1 + CASE_STEP : byte_s1;
		is_digit = byte_s1 >= CH_0 && byte_s1 <= CH_9;
		is_alnum = is_digit || (byte_s1 >= CH_LA && byte_s1 <= CH_LZ) ||
			(byte_s1 >= CH_UA && byte_s1 <= CH_UZ) || byte_s1 == CH_DASH;
		pv = 20'(port_q) * 20'd10 + 20'(byte_s1 - CH_0);

		unique case (phase_q)
			PH_SCHEME: begin
				unique case (spos_q)
					3'd0: begin ok = lc == CH_H; n_spos = 3'd1; end
					3'd1: begin ok = lc == CH_T; n_spos = 3'd2; end
					3'd2: begin ok = lc == CH_T; n_spos = 3'd3; end
					3'd3: begin ok = lc == CH_P; n_spos = 3'd4; end
					3'd4: begin
						if (lc == CH_S) begin
							n_secure = 1'b1;
							n_spos   = 3'd5;
							ok       = 1'b1;
						end else begin
							ok     = byte_s1 == CH_COLON;
							n_spos = 3'd6;
						end
					end
					3'd5: begin ok = byte_s1 == CH_COLON; n_spos = 3'd6; end
					3'd6: begin ok = byte_s1 == CH_SLASH; n_spos = 3'd7; end
					default: begin
						ok = byte_s1 == CH_SLASH;
						if (ok) n_phase = PH_HOST;
					end
				endcase
				if (!ok) begin
					n_spos  = spos_q;
					n_err   = ST_BAD_SCHEME;
					n_phase = PH_IGNORE;
				end
			end
			PH_HOST: begin
				if (is_alnum) begin
					res[nres].kind = KIND_HOST;
					res[nres].text = lc;
					nres = nres + 2'd1;
					n_dot_ok = 1'b1;
					if (hcount_q < HOST_MIN) n_hcount = hcount_q + 3'd1;
				end else if (byte_s1 == CH_DOT && dot_ok_q) begin
					res[nres].kind = KIND_HOST;
					res[nres].text = byte_s1;
					nres = nres + 2'd1;
					n_seen_dot = 1'b1;
					n_dot_ok   = 1'b0;
					if (hcount_q < HOST_MIN) n_hcount = hcount_q + 3'd1;
				end else begin
					host_bad = hcount_q < HOST_MIN || !seen_dot_q || !dot_ok_q;
					if (host_bad) begin
						n_err   = ST_BAD_HOST;
						n_phase = PH_IGNORE;
					end else if (byte_s1 == CH_COLON) begin
						n_phase = PH_PORT;
					end else if (byte_s1 == CH_SLASH) begin
						n_slash = 1'b1;
						n_phase = PH_PATH;
					end else begin
						n_phase = PH_IGNORE;
					end
				end
			end
			PH_PORT: begin
				if (is_digit) begin
					n_pdigit = 1'b1;
					if (povf_q || (|pv[19:16])) n_povf = 1'b1;
					else n_port = pv[15:0];
				end else if (!pdigit_q || povf_q) begin
					n_err   = ST_BAD_PORT;
					n_phase = PH_IGNORE;
				end else if (byte_s1 == CH_SLASH) begin
					n_slash = 1'b1;
					n_phase = PH_PATH;
				end else begin
					n_phase = PH_IGNORE;
				end
			end
			PH_PATH: begin
				if (slash_q) begin
					res[nres].kind = KIND_PATH;
					res[nres].text = CH_SLASH;
					nres = nres + 2'd1;
					n_slash = 1'b0;
					n_path  = 1'b1;
				end
				res[nres].kind = KIND_PATH;
				res[nres].text = byte_s1;
				nres = nres + 2'd1;
			end
			default: ;
		endcase

		if (final_s1) begin
			// close whatever phase the url ended in
			if (n_phase == PH_SCHEME) begin
				n_err = ST_BAD_SCHEME;
			end else if (n_phase == PH_HOST) begin
				if (n_hcount < HOST_MIN || !n_seen_dot || !n_dot_ok) n_err = ST_BAD_HOST;
			end else if (n_phase == PH_PORT) begin
				port_bad = !n_pdigit || n_povf;
				if (port_bad) n_err = ST_BAD_PORT;
			end
			given = n_pdigit && !n_povf && !(n_port == PORT_HTTP && !n_secure) &&
				!(n_port == PORT_HTTPS && n_secure);
			res[nres].kind   = KIND_FINAL;
			res[nres].status = n_err;
			if (n_err == ST_OK) begin
				res[nres].secure     = n_secure;
				res[nres].port_given = given;
				res[nres].port_num   = given ? n_port : 16'd0;
				res[nres].path_given = n_path;
			end
			nres = nres + 2'd1;

			n_phase    = PH_SCHEME;
			n_spos     = 3'd0;
			n_secure   = 1'b0;
			n_dot_ok   = 1'b0;
			n_seen_dot = 1'b0;
			n_hcount   = 3'd0;
			n_port     = 16'd0;
			n_pdigit   = 1'b0;
			n_povf     = 1'b0;
			n_slash    = 1'b0;
			n_path     = 1'b0;
			n_err      = ST_OK;
		end

		if (nres != 2'd0) res[nres - 2'd1].run_end = 1'b1;
	end

	assign out_valid = cnt_q != 2'd0;
	assign out_acc   = out_valid && out_ready;
	// the buffer takes a new batch only once it is empty or about to be
	assign room      = cnt_q == 2'd0 || (cnt_q == 2'd1 && out_acc);
	assign take      = valid_s1 && (nres == 2'd0 || room);
	assign load      = take && nres != 2'd0;
	assign in_ready  = !valid_s1 || take;
	assign in_acc    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			cnt_q      <= 2'd0;
			phase_q    <= PH_SCHEME;
			spos_q     <= 3'd0;
			secure_q   <= 1'b0;
			dot_ok_q   <= 1'b0;
			seen_dot_q <= 1'b0;
			hcount_q   <= 3'd0;
			port_q     <= 16'd0;
			pdigit_q   <= 1'b0;
			povf_q     <= 1'b0;
			slash_q    <= 1'b0;
			path_q     <= 1'b0;
			err_q      <= ST_OK;
		end else begin
			if (in_acc) valid_s1 <= 1'b1;
			else if (take) valid_s1 <= 1'b0;
			cnt_q <= cnt_q - {1'b0, out_acc} + (load ? nres : 2'd0);
			if (take) begin
				phase_q    <= n_phase;
				spos_q     <= n_spos;
				secure_q   <= n_secure;
				dot_ok_q   <= n_dot_ok;
				seen_dot_q <= n_seen_dot;
				hcount_q   <= n_hcount;
				port_q     <= n_port;
				pdigit_q   <= n_pdigit;
				povf_q     <= n_povf;
				slash_q    <= n_slash;
				path_q     <= n_path;
				err_q      <= n_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1  <= url_byte;
			final_s1 <= final_byte;
		end
		if (load) begin
			slot_q <= res;
		end else if (out_acc) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	assign item_kind     = slot_q[0].kind;
	assign text_byte     = slot_q[0].text;
	assign status        = slot_q[0].status;
	assign secure_scheme = slot_q[0].secure;
	assign port_given    = slot_q[0].port_given;
	assign port_number   = slot_q[0].port_num;
	assign path_given    = slot_q[0].path_given;
	assign run_end       = slot_q[0].run_end;

`ifndef NO_ASSERTIONS
	a_final_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_FINAL |-> run_end)
		else $error("summary item without run_end");

	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> cnt_q == 2'd0 || (cnt_q == 2'd1 && out_acc))
		else $error("result batch loaded over pending results");

	a_text_items_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != KIND_FINAL |-> status == ST_OK && !port_given &&
			port_number == 16'd0 && !path_given && !secure_scheme)
		else $error("summary fields set on a text item");
`endif

endmodule
